[hdl/kgd_pkg.sv]
// ----------------------------------------------------------------------------
// Key gesture detector package
// Shared widths, codes, per-key state type and parameter defaults.
// ----------------------------------------------------------------------------
package kgd_pkg;

  localparam int NUM_KEYS_DEF    = 8;
  localparam int FIFO_SLOTS_DEF  = 10;
  localparam int SCAN_PERIOD_DEF = 20;

  localparam int CMD_W      = 2;
  localparam int LEVEL_W    = 8;
  localparam int KEY_IDX_W  = 3;
  localparam int ACT_W      = 4;
  localparam int TIMER_W    = 16;
  localparam int FLAG_W     = 6;
  localparam int DIV_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  localparam logic [ACT_W-1:0]   ACTIVE_KEYS_RST = 4'd0;
  localparam logic [TIMER_W-1:0] LONG_TICKS_RST  = 16'd1000;
  localparam logic [TIMER_W-1:0] DOUBLE_TICKS_RST = 16'd300;
  localparam logic [TIMER_W-1:0] REPEAT_TICKS_RST = 16'd200;
  localparam logic [LEVEL_W-1:0] PRESS_MASK_RST  = 8'h00;

  localparam logic [FLAG_W-1:0] FLAG_NONE   = 6'h00;
  localparam logic [FLAG_W-1:0] FLAG_DOWN   = 6'h01;
  localparam logic [FLAG_W-1:0] FLAG_UP     = 6'h02;
  localparam logic [FLAG_W-1:0] FLAG_CLICK  = 6'h04;
  localparam logic [FLAG_W-1:0] FLAG_DOUBLE = 6'h08;
  localparam logic [FLAG_W-1:0] FLAG_LONG   = 6'h10;
  localparam logic [FLAG_W-1:0] FLAG_REPEAT = 6'h20;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } kgd_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_KEYS  = 3'd0,
    CFG_LONG_TICKS   = 3'd1,
    CFG_DOUBLE_TICKS = 3'd2,
    CFG_REPEAT_TICKS = 3'd3,
    CFG_PRESS_MASK   = 3'd4
  } kgd_cfg_e;

  typedef enum logic [4:0] {
    G_IDLE       = 5'b00001,
    G_HELD       = 5'b00010,
    G_WAIT_2ND   = 5'b00100,
    G_HELD_2ND   = 5'b01000,
    G_REPEATING  = 5'b10000
  } kgd_gst_e;

  typedef struct packed {
    logic               prev;
    logic               cur;
    kgd_gst_e           gst;
    logic [TIMER_W-1:0] timer;
  } kgd_key_t;

  typedef struct packed {
    logic [TIMER_W-1:0] long_ticks;
    logic [TIMER_W-1:0] double_ticks;
    logic [TIMER_W-1:0] repeat_ticks;
  } kgd_timing_t;

endpackage

[hdl/kgd_key_step.sv]
// ----------------------------------------------------------------------------
// Key gesture step unit
// Shared per-key update: timer countdown, edge flags and gesture machine.
// ----------------------------------------------------------------------------
module kgd_key_step (
  input  kgd_pkg::kgd_key_t                key_i,
  input  logic                             now_i,
  input  logic                             scan_i,
  input  kgd_pkg::kgd_timing_t             timing_i,
  output kgd_pkg::kgd_key_t                key_o,
  output logic [kgd_pkg::FLAG_W-1:0]       flags_o
);
  import kgd_pkg::*;

  logic [TIMER_W-1:0] tmr;

  always_comb begin
    tmr     = (key_i.timer != '0) ? key_i.timer - TIMER_W'(1) : key_i.timer;
    key_o   = key_i;
    key_o.timer = tmr;
    flags_o = FLAG_NONE;
    if (scan_i) begin
      key_o.prev = key_i.cur;
      key_o.cur  = now_i;
      if (!key_i.cur && now_i) begin
        flags_o = flags_o | FLAG_DOWN;
      end else if (key_i.cur && !now_i) begin
        flags_o = flags_o | FLAG_UP;
      end
      case (key_i.gst)
        G_IDLE: begin
          if (now_i) begin
            key_o.timer = timing_i.long_ticks;
            key_o.gst   = G_HELD;
          end
        end
        G_HELD: begin
          if (!now_i) begin
            key_o.timer = timing_i.double_ticks;
            key_o.gst   = G_WAIT_2ND;
          end else if (tmr == '0) begin
            key_o.timer = timing_i.repeat_ticks;
            key_o.gst   = G_REPEATING;
            flags_o     = flags_o | FLAG_LONG;
          end
        end
        G_WAIT_2ND: begin
          if (now_i) begin
            key_o.gst = G_HELD_2ND;
            flags_o   = flags_o | FLAG_DOUBLE;
          end else if (tmr == '0) begin
            key_o.gst = G_IDLE;
            flags_o   = flags_o | FLAG_CLICK;
          end
        end
        G_HELD_2ND: begin
          if (!now_i) begin
            key_o.gst = G_IDLE;
          end
        end
        G_REPEATING: begin
          if (!now_i) begin
            key_o.gst = G_IDLE;
          end else if (tmr == '0) begin
            key_o.timer = timing_i.repeat_ticks;
            flags_o     = flags_o | FLAG_REPEAT;
          end
        end
        default: begin
          key_o.gst = key_i.gst;
        end
      endcase
    end
  end

endmodule

[hdl/kgd_event_ram.sv]
// ----------------------------------------------------------------------------
// Key gesture event store
// One write port and one registered read port over all key FIFOs.
// ----------------------------------------------------------------------------
module kgd_event_ram #(
  parameter int DEPTH = kgd_pkg::NUM_KEYS_DEF * kgd_pkg::FIFO_SLOTS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [kgd_pkg::FLAG_W-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [kgd_pkg::FLAG_W-1:0]  rdata_o
);
  import kgd_pkg::*;

  logic [FLAG_W-1:0] mem [DEPTH];
  logic [FLAG_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/key_gesture_detector_fifo_unit.sv]
// ----------------------------------------------------------------------------
// Key gesture detector with per-key event FIFOs
// Tick: the shared step unit visits one active key per cycle, and the input
//   is held until the last one (active keys, capped at NUM_KEYS) is visited.
// Read: event store read is registered, then goes to the output register;
//   the input is held until that load, longer while an earlier result waits.
// Clear and unused commands do not hold the input. Reset clears all control
//   and key state; the event store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module key_gesture_detector_fifo_unit #(
  parameter int NUM_KEYS    = kgd_pkg::NUM_KEYS_DEF,
  parameter int FIFO_SLOTS  = kgd_pkg::FIFO_SLOTS_DEF,
  parameter int SCAN_PERIOD = kgd_pkg::SCAN_PERIOD_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // key_levels[7:0], key_index[10:8], zero pad [15:11]
  input  logic [kgd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // cmd[1:0]
  input  logic [kgd_pkg::CMD_W-1:0]        s_axis_tuser,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // event_flags[5:0], zero pad [7:6]
  output logic [kgd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // fifo_was_empty[0]
  output logic                             m_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [kgd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [kgd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import kgd_pkg::*;

  localparam int KW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CW    = $clog2(NUM_KEYS + 1);
  localparam int PW    = $clog2(FIFO_SLOTS);
  localparam int DEPTH = NUM_KEYS * FIFO_SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TICK = 3'b010,
    S_READ = 3'b100
  } seq_state_e;

  function automatic logic [PW-1:0] slot_after(input logic [PW-1:0] p);
    return (p == PW'(FIFO_SLOTS - 1)) ? '0 : p + PW'(1);
  endfunction

  seq_state_e          st_q, st_d;
  logic [KW-1:0]       k_q;
  logic [LEVEL_W-1:0]  levels_q;
  logic                scan_q;
  logic                hit_q;
  logic [DIV_W-1:0]    div_q;

  logic [ACT_W-1:0]    active_keys_q;
  kgd_timing_t         timing_q;
  logic [LEVEL_W-1:0]  press_mask_q;

  kgd_key_t            key_q [NUM_KEYS];
  logic [PW-1:0]       rp_q  [NUM_KEYS];
  logic [PW-1:0]       wp_q  [NUM_KEYS];

  logic                out_valid_q;
  logic [FLAG_W-1:0]   out_flags_q;
  logic                out_empty_q;

  kgd_cmd_e            cmd;
  logic [LEVEL_W-1:0]  in_levels;
  logic [KEY_IDX_W-1:0] in_key;
  logic [KW-1:0]       ridx;
  logic                idx_ok;
  logic                rd_hit;
  logic                s_acc;
  logic [CW-1:0]       n_eff;
  logic                proc;
  logic                last_key;
  logic [DIV_W-1:0]    div_next;
  logic                now;
  kgd_key_t            key_nxt;
  logic [FLAG_W-1:0]   flags;
  logic                ram_we;
  logic                ram_re;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic [FLAG_W-1:0]   rdata;
  logic                out_load;

  assign cmd       = kgd_cmd_e'(s_axis_tuser);
  assign in_levels = s_axis_tdata[7:0];
  assign in_key    = s_axis_tdata[10:8];
  assign ridx      = KW'(in_key);
  assign idx_ok    = 32'(in_key) < NUM_KEYS;
  assign rd_hit    = idx_ok && (rp_q[ridx] != wp_q[ridx]);

  assign s_axis_tready = (st_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    if (32'(active_keys_q) > NUM_KEYS) begin
      n_eff = CW'(NUM_KEYS);
    end else begin
      n_eff = CW'(active_keys_q);
    end
  end

  assign proc     = (st_q == S_TICK) && (n_eff != '0);
  assign last_key = (n_eff == '0) || (CW'(k_q) == n_eff - CW'(1));
  assign div_next = div_q + DIV_W'(1);
  assign now      = (32'(k_q) < 32'd8) &&
                    (levels_q[3'(k_q)] == press_mask_q[3'(k_q)]);

  kgd_key_step u_step (
    .key_i    (key_q[k_q]),
    .now_i    (now),
    .scan_i   (scan_q),
    .timing_i (timing_q),
    .key_o    (key_nxt),
    .flags_o  (flags)
  );

  assign ram_we = proc && (flags != FLAG_NONE) && (slot_after(wp_q[k_q]) != rp_q[k_q]);
  assign waddr  = AW'(k_q) * AW'(FIFO_SLOTS) + AW'(wp_q[k_q]);
  assign ram_re = s_acc && (cmd == CMD_READ) && rd_hit;
  assign raddr  = AW'(ridx) * AW'(FIFO_SLOTS) + AW'(rp_q[ridx]);

  kgd_event_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (flags),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_load = (st_q == S_READ) && (!out_valid_q || m_axis_tready);

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (s_acc && cmd == CMD_TICK) begin
          st_d = S_TICK;
        end else if (s_acc && cmd == CMD_READ) begin
          st_d = S_READ;
        end
      end
      S_TICK: begin
        if (last_key) begin
          st_d = S_IDLE;
        end
      end
      S_READ: begin
        if (out_load) begin
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      k_q   <= '0;
      div_q <= '0;
    end else begin
      st_q <= st_d;
      if (s_acc && cmd == CMD_TICK) begin
        k_q   <= '0;
        div_q <= (div_next >= DIV_W'(SCAN_PERIOD)) ? '0 : div_next;
      end else if (st_q == S_TICK && !last_key) begin
        k_q <= k_q + KW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      levels_q <= in_levels;
      scan_q   <= div_next >= DIV_W'(SCAN_PERIOD);
      hit_q    <= rd_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_keys_q         <= ACTIVE_KEYS_RST;
      timing_q.long_ticks   <= LONG_TICKS_RST;
      timing_q.double_ticks <= DOUBLE_TICKS_RST;
      timing_q.repeat_ticks <= REPEAT_TICKS_RST;
      press_mask_q          <= PRESS_MASK_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (kgd_cfg_e'(cfg_index_i))
        CFG_ACTIVE_KEYS:  active_keys_q         <= cfg_data_i[ACT_W-1:0];
        CFG_LONG_TICKS:   timing_q.long_ticks   <= cfg_data_i[TIMER_W-1:0];
        CFG_DOUBLE_TICKS: timing_q.double_ticks <= cfg_data_i[TIMER_W-1:0];
        CFG_REPEAT_TICKS: timing_q.repeat_ticks <= cfg_data_i[TIMER_W-1:0];
        CFG_PRESS_MASK:   press_mask_q          <= cfg_data_i[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_q[i] <= '{prev: 1'b0, cur: 1'b0, gst: G_IDLE, timer: '0};
        rp_q[i]  <= '0;
        wp_q[i]  <= '0;
      end
    end else begin
      if (proc) begin
        key_q[k_q] <= key_nxt;
      end
      if (ram_we) begin
        wp_q[k_q] <= slot_after(wp_q[k_q]);
      end
      if (ram_re) begin
        rp_q[ridx] <= slot_after(rp_q[ridx]);
      end
      if (s_acc && cmd == CMD_CLEAR && idx_ok) begin
        rp_q[ridx] <= '0;
        wp_q[ridx] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_flags_q <= hit_q ? rdata : FLAG_NONE;
      out_empty_q <= !hit_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_flags_q};
  assign m_axis_tuser  = out_empty_q;

  a_read_enters_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && cmd == CMD_READ) |=> (st_q == S_READ))
    else $error("read request did not enter the result wait");

  a_read_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_READ && m_axis_tvalid && !m_axis_tready) |=>
    (st_q == S_READ && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("pending read result overwritten while stalled");

  a_key_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |-> (CW'(k_q) < n_eff))
    else $error("tick visits a key beyond the active count");

endmodule

[test/tb_key_gesture_detector_fifo_unit.sv]
// ----------------------------------------------------------------------------
// Key gesture detector FIFO unit testbench
// Drives tick, read, clear and unused requests over a series of timing and
// polarity setups. A predictor tracks per-key gesture state and event FIFOs,
// and every read result is checked against it. Both stream sides stall at
// random, except for one setup that runs with no stalls.
// ----------------------------------------------------------------------------
module tb_key_gesture_detector_fifo_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import kgd_pkg::*;

  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    logic              empty;
  } read_result_t;

  class key_event_predictor;
    logic [ACT_W-1:0]   active_keys;
    logic [TIMER_W-1:0] long_ticks;
    logic [TIMER_W-1:0] double_ticks;
    logic [TIMER_W-1:0] repeat_ticks;
    logic [LEVEL_W-1:0] press_mask;

    logic [DIV_W-1:0]   scan_count;
    bit                 was_pressed[NUM_KEYS_DEF];
    bit                 cur_pressed[NUM_KEYS_DEF];
    kgd_gst_e           key_state[NUM_KEYS_DEF];
    logic [TIMER_W-1:0] key_timer[NUM_KEYS_DEF];
    logic [FLAG_W-1:0]  event_ring[NUM_KEYS_DEF][FIFO_SLOTS_DEF];
    int unsigned        rd_ptr[NUM_KEYS_DEF];
    int unsigned        wr_ptr[NUM_KEYS_DEF];

    read_result_t       queued_reads[$];

    int unsigned n_ticks, n_reads, n_clears, n_unused, n_scans;
    int unsigned n_events, n_dropped, n_checked, n_hits, mismatches;

    function new();
      active_keys  = ACTIVE_KEYS_RST;
      long_ticks   = LONG_TICKS_RST;
      double_ticks = DOUBLE_TICKS_RST;
      repeat_ticks = REPEAT_TICKS_RST;
      press_mask   = PRESS_MASK_RST;
      scan_count   = '0;
      for (int k = 0; k < NUM_KEYS_DEF; k++) begin
        was_pressed[k] = 1'b0;
        cur_pressed[k] = 1'b0;
        key_state[k]   = G_IDLE;
        key_timer[k]   = '0;
        rd_ptr[k]      = 0;
        wr_ptr[k]      = 0;
      end
    endfunction

    function void set_register(kgd_cfg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ACTIVE_KEYS:  active_keys  = data[ACT_W-1:0];
        CFG_LONG_TICKS:   long_ticks   = data[TIMER_W-1:0];
        CFG_DOUBLE_TICKS: double_ticks = data[TIMER_W-1:0];
        CFG_REPEAT_TICKS: repeat_ticks = data[TIMER_W-1:0];
        CFG_PRESS_MASK:   press_mask   = data[LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned next_slot(int unsigned p);
      return (p == FIFO_SLOTS_DEF - 1) ? 0 : p + 1;
    endfunction

    function void push_event(int k, logic [FLAG_W-1:0] flags);
      if (next_slot(wr_ptr[k]) != rd_ptr[k]) begin
        event_ring[k][wr_ptr[k]] = flags;
        wr_ptr[k] = next_slot(wr_ptr[k]);
        n_events++;
      end else begin
        n_dropped++;
      end
    endfunction

    function void scan_key(int k, bit now);
      logic [FLAG_W-1:0] flags;
      flags = FLAG_NONE;
      was_pressed[k] = cur_pressed[k];
      cur_pressed[k] = now;
      if (!was_pressed[k] && now) flags |= FLAG_DOWN;
      else if (was_pressed[k] && !now) flags |= FLAG_UP;
      case (key_state[k])
        G_IDLE: begin
          if (now) begin
            key_timer[k] = long_ticks;
            key_state[k] = G_HELD;
          end
        end
        G_HELD: begin
          if (!now) begin
            key_timer[k] = double_ticks;
            key_state[k] = G_WAIT_2ND;
          end else if (key_timer[k] == '0) begin
            key_timer[k] = repeat_ticks;
            flags |= FLAG_LONG;
            key_state[k] = G_REPEATING;
          end
        end
        G_WAIT_2ND: begin
          if (now) begin
            flags |= FLAG_DOUBLE;
            key_state[k] = G_HELD_2ND;
          end else if (key_timer[k] == '0) begin
            flags |= FLAG_CLICK;
            key_state[k] = G_IDLE;
          end
        end
        G_HELD_2ND: begin
          if (!now) key_state[k] = G_IDLE;
        end
        G_REPEATING: begin
          if (!now) begin
            key_state[k] = G_IDLE;
          end else if (key_timer[k] == '0) begin
            key_timer[k] = repeat_ticks;
            flags |= FLAG_REPEAT;
          end
        end
        default: ;
      endcase
      if (flags != FLAG_NONE) push_event(k, flags);
    endfunction

    function void advance_tick(logic [LEVEL_W-1:0] levels);
      int n;
      n = (active_keys > NUM_KEYS_DEF) ? NUM_KEYS_DEF : int'(active_keys);
      for (int k = 0; k < n; k++)
        if (key_timer[k] != '0) key_timer[k] = key_timer[k] - 1'b1;
      scan_count = scan_count + 1'b1;
      if (scan_count < SCAN_PERIOD_DEF) return;
      scan_count = '0;
      n_scans++;
      for (int k = 0; k < n; k++)
        scan_key(k, levels[k] == press_mask[k]);
    endfunction

    function void accept_request(kgd_cmd_e op, logic [LEVEL_W-1:0] levels,
                                 logic [KEY_IDX_W-1:0] key);
      read_result_t res;
      case (op)
        CMD_TICK: begin
          n_ticks++;
          advance_tick(levels);
        end
        CMD_READ: begin
          n_reads++;
          res.flags = FLAG_NONE;
          res.empty = 1'b1;
          if (rd_ptr[key] != wr_ptr[key]) begin
            res.flags = event_ring[key][rd_ptr[key]];
            res.empty = 1'b0;
            rd_ptr[key] = next_slot(rd_ptr[key]);
            n_hits++;
          end
          queued_reads.push_back(res);
        end
        CMD_CLEAR: begin
          n_clears++;
          rd_ptr[key] = 0;
          wr_ptr[key] = 0;
        end
        default: n_unused++;
      endcase
    endfunction

    function void check_read(logic [OUT_DATA_W-1:0] beat, logic empty_bit);
      read_result_t want;
      if (queued_reads.size() == 0) begin
        $display("%0t: unexpected read result, expected none, actual %h %b", $time, beat,
                 empty_bit);
        mismatches++;
        return;
      end
      want = queued_reads.pop_front();
      n_checked++;
      if (beat[FLAG_W-1:0] !== want.flags) begin
        $display("%0t: event_flags expected %h actual %h", $time, want.flags,
                 beat[FLAG_W-1:0]);
        mismatches++;
      end
      if (empty_bit !== want.empty) begin
        $display("%0t: fifo_was_empty expected %b actual %b", $time, want.empty,
                 empty_bit);
        mismatches++;
      end
    endfunction

    function int pending();
      return queued_reads.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [CMD_W-1:0]      s_axis_tuser;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bit                    steady_flow;
  key_event_predictor    predictor;

  key_gesture_detector_fifo_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= steady_flow || ($urandom_range(99) >= 27);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      predictor.check_read(m_axis_tdata, m_axis_tuser);
  end

  task automatic send_request(input kgd_cmd_e op, input logic [LEVEL_W-1:0] levels,
                              input logic [KEY_IDX_W-1:0] key);
    while (!steady_flow && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {5'b00000, key, levels};
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predictor.accept_request(op, levels, key);
    @(negedge clk_i);
  endtask

  task automatic write_register(input kgd_cfg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    predictor.set_register(idx, data);
    @(negedge clk_i);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (predictor.pending() > 0 && waited < 4000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (20) @(negedge clk_i);
  endtask

  task automatic apply_setup(input logic [CFG_DATA_W-1:0] active,
                             input logic [CFG_DATA_W-1:0] long_t,
                             input logic [CFG_DATA_W-1:0] double_t,
                             input logic [CFG_DATA_W-1:0] repeat_t,
                             input logic [CFG_DATA_W-1:0] mask);
    settle();
    write_register(CFG_ACTIVE_KEYS, active);
    write_register(CFG_LONG_TICKS, long_t);
    write_register(CFG_DOUBLE_TICKS, double_t);
    write_register(CFG_REPEAT_TICKS, repeat_t);
    write_register(CFG_PRESS_MASK, mask);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_session(input int n_items, input int read_pct);
    logic [LEVEL_W-1:0] pins;
    int roll;
    pins = LEVEL_W'($urandom);
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(99);
      if (roll < read_pct) begin
        send_request(CMD_READ, LEVEL_W'($urandom), KEY_IDX_W'($urandom_range(7)));
      end else if (roll < read_pct + 3) begin
        send_request(CMD_CLEAR, LEVEL_W'($urandom), KEY_IDX_W'($urandom_range(7)));
      end else if (roll < read_pct + 5) begin
        send_request(CMD_NONE, LEVEL_W'($urandom), KEY_IDX_W'($urandom_range(7)));
      end else begin
        if ($urandom_range(9) == 0) pins ^= 8'd1 << $urandom_range(7);
        if ($urandom_range(49) == 0)
          send_request(CMD_TICK, LEVEL_W'($urandom), KEY_IDX_W'($urandom_range(7)));
        else send_request(CMD_TICK, pins, KEY_IDX_W'($urandom_range(7)));
      end
    end
  endtask

  initial begin
    predictor     = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_ACTIVE_KEYS;
    cfg_data_i    = '0;
    steady_flow   = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset defaults: no key active, all FIFOs empty
    send_request(CMD_READ, 8'h00, 3'd0);
    send_request(CMD_READ, 8'hFF, 3'd7);
    send_request(CMD_NONE, 8'hFF, 3'd7);
    send_request(CMD_CLEAR, 8'h00, 3'd3);
    send_request(CMD_TICK, 8'h00, 3'd0);
    send_request(CMD_TICK, 8'hFF, 3'd7);
    send_request(CMD_READ, 8'h55, 3'd3);

    apply_setup(16'd8, 16'd0, 16'd0, 16'd0, 16'h0000);
    run_session(250, 12);

    apply_setup(16'd15, 16'd30, 16'd50, 16'd20, 16'h00FF);
    steady_flow = 1'b1;
    run_session(300, 4);
    steady_flow = 1'b0;

    apply_setup(16'd3, 16'd40, 16'd60, 16'd0, 16'h00A5);
    run_session(200, 14);

    apply_setup(16'd8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h005A);
    run_session(150, 12);

    apply_setup(16'd0, 16'd10, 16'd10, 16'd10, 16'h0000);
    run_session(100, 20);

    apply_setup(16'd8, CFG_DATA_W'($urandom_range(80)), CFG_DATA_W'($urandom_range(80)),
                CFG_DATA_W'($urandom_range(40)), CFG_DATA_W'($urandom_range(255)));
    run_session(300, 12);

    apply_setup(16'd5, 16'd25, 16'd45, 16'd15, 16'h003C);
    run_session(200, 12);

    settle();
    if (predictor.pending() > 0) begin
      $display("%0t: %0d read results expected but never returned", $time,
               predictor.pending());
      predictor.mismatches++;
    end

    $display("Covered %0d requests: %0d ticks (%0d scans), %0d reads, %0d clears, %0d unused",
             predictor.n_ticks + predictor.n_reads + predictor.n_clears + predictor.n_unused,
             predictor.n_ticks, predictor.n_scans, predictor.n_reads, predictor.n_clears,
             predictor.n_unused);
    $display("Queued %0d events, dropped %0d on full FIFOs, checked %0d reads (%0d nonempty)",
             predictor.n_events, predictor.n_dropped, predictor.n_checked, predictor.n_hits);
    if (predictor.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
